// ===== sv/tsb_pkg.sv =====
package tsb_pkg;

    // operation codes carried in the func field
    localparam logic [2:0] FUNC_CREATE = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_PAUSE  = 3'd2;
    localparam logic [2:0] FUNC_RESUME = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;
    localparam logic [2:0] FUNC_TICK   = 3'd5;
    localparam logic [2:0] FUNC_QUERY  = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // fired results reported per tick
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] timer_id;
        logic [31:0] interval_us;
        logic        periodic;
        logic [31:0] delta_us;
    } tsb_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic        fired;
        logic        found;
        logic [31:0] remaining_us;
        logic        last;
    } tsb_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sweep_rd;
        logic pick_mode;
        logic pick_start;
        logic commit;
        logic emit_fire;
        logic emit_none;
    } tsb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic fire_any;
        logic fire_last;
        logic out_free;
    } tsb_sts_t;

endpackage

// ===== sv/tsb_ram.sv =====
module tsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                            aclk,
    input  logic                                            wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
    input  logic [WIDTH-1:0]                                wr_data,
    input  logic                                            rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
    output logic [WIDTH-1:0]                                rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tsb_ctrl.sv =====
module tsb_ctrl import tsb_pkg::*; #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    s_valid,
    output logic                                                    s_ready,
    input  tsb_sts_t                                                sts,
    output tsb_cmd_t                                                cmd,
    output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] sweep_addr
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SWEEP   = 6'b000010,
        S_COMMIT  = 6'b000100,
        S_TICKEND = 6'b001000,
        S_PICK    = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sweep_more;

    assign s_ready    = (state_reg == S_IDLE);
    assign sweep_more = (cnt_reg < CW'(TIMER_SLOTS));
    assign sweep_addr = AW'(cnt_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // last read data is processed in the cycle the count hits the end
                if (sweep_more) begin
                    cmd.sweep_rd = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end else if (sts.is_tick) begin
                    state_next = S_TICKEND;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICKEND: begin
                if (!sts.fire_any) begin
                    if (sts.out_free) begin
                        cmd.emit_none = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.pick_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_PICK;
                end
            end
            S_PICK: begin
                cmd.pick_mode = 1'b1;
                if (sweep_more) begin
                    cmd.sweep_rd = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_fire = 1'b1;
                    if (sts.fire_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.pick_start = 1'b1;
                        cnt_next       = '0;
                        state_next     = S_PICK;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TIMER_SLOTS))
        else $error("sweep count past slot range");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.sweep_rd, cmd.commit, cmd.emit_fire, cmd.emit_none}))
        else $error("more than one datapath action in a cycle");
`endif

endmodule

// ===== sv/tsb_dp.sv =====
module tsb_dp import tsb_pkg::*; #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  tsb_req_t                                                s_req,
    input  tsb_cmd_t                                                cmd,
    input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] sweep_addr,
    output tsb_sts_t                                                sts,
    output logic                                                    m_valid,
    input  logic                                                    m_ready,
    output tsb_rsp_t                                                m_rsp
);

    localparam int AW       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int ECW      = $clog2(MAX_RESULTS);
    // slot word: ident, interval, elapsed, reload, halted
    localparam int HALT_B   = 0;
    localparam int RELOAD_B = 1;
    localparam int ELAP_LO  = 2;
    localparam int IVL_LO   = 2 + TIME_BITS;
    localparam int ID_LO    = 2 + 2 * TIME_BITS;
    localparam int WW       = 34 + 2 * TIME_BITS;

    // request
    logic [2:0]           func_reg, func_next;
    logic [31:0]          tid_reg, tid_next;
    logic                 per_reg, per_next;
    logic [TIME_BITS-1:0] ivl_reg, ivl_next;
    logic [TIME_BITS-1:0] delta_reg, delta_next;
    logic [TIME_BITS-1:0] ivl_sat, delta_sat;

    // slot flags
    logic [TIMER_SLOTS-1:0] live_reg, live_next;
    logic [TIMER_SLOTS-1:0] fire_reg, fire_next;
    logic [TIMER_SLOTS-1:0] pick_onehot;
    logic [31:0]            id_cnt_reg, id_cnt_next;

    // sweep trackers
    logic          free_found_reg, free_found_next;
    logic [AW-1:0] free_slot_reg, free_slot_next;
    logic          match_found_reg, match_found_next;
    logic [AW-1:0] match_slot_reg, match_slot_next;
    logic [WW-1:0] match_word_reg, match_word_next;
    logic          pick_found_reg, pick_found_next;
    logic [AW-1:0] pick_slot_reg, pick_slot_next;
    logic [31:0]   pick_id_reg, pick_id_next;
    logic [ECW-1:0] emit_cnt_reg, emit_cnt_next;

    // read pipeline
    logic          proc_valid_reg;
    logic [AW-1:0] proc_addr_reg;
    logic          proc_pick_reg;

    // output register
    logic     m_valid_reg, m_valid_next;
    tsb_rsp_t m_rsp_reg, m_rsp_next;
    logic     out_free;

    // ram
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [WW-1:0] ram_wr_data;
    logic [WW-1:0] ram_rd_data;

    logic [31:0]          rd_id;
    logic [TIME_BITS-1:0] rd_ivl, rd_elap;
    logic                 rd_reload, rd_halt, rd_live;
    logic [TIME_BITS:0]   elap_sum;
    logic [TIME_BITS-1:0] elap_new;
    logic                 expire;

    logic [TIME_BITS-1:0] m_ivl, m_elap, rem_diff;
    logic [31:0]          rem32;
    logic [31:0]          new_id;
    logic                 fire_last;

    tsb_ram #(
        .WIDTH (WW),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.sweep_rd),
        .rd_addr (sweep_addr),
        .rd_data (ram_rd_data)
    );

    // times wider than TIME_BITS saturate
    if (TIME_BITS >= 32) begin : g_wide_in
        assign ivl_sat   = TIME_BITS'(s_req.interval_us);
        assign delta_sat = TIME_BITS'(s_req.delta_us);
    end else begin : g_narrow_in
        assign ivl_sat   = (s_req.interval_us[31:TIME_BITS] != '0) ? '1
                           : s_req.interval_us[TIME_BITS-1:0];
        assign delta_sat = (s_req.delta_us[31:TIME_BITS] != '0) ? '1
                           : s_req.delta_us[TIME_BITS-1:0];
    end

    assign m_ivl    = match_word_reg[IVL_LO +: TIME_BITS];
    assign m_elap   = match_word_reg[ELAP_LO +: TIME_BITS];
    assign rem_diff = (m_elap > m_ivl) ? '0 : (m_ivl - m_elap);

    if (TIME_BITS > 32) begin : g_wide_rem
        assign rem32 = (rem_diff[TIME_BITS-1:32] != '0) ? '1 : rem_diff[31:0];
    end else begin : g_narrow_rem
        assign rem32 = 32'(rem_diff);
    end

    assign rd_id     = ram_rd_data[ID_LO +: 32];
    assign rd_ivl    = ram_rd_data[IVL_LO +: TIME_BITS];
    assign rd_elap   = ram_rd_data[ELAP_LO +: TIME_BITS];
    assign rd_reload = ram_rd_data[RELOAD_B];
    assign rd_halt   = ram_rd_data[HALT_B];
    assign rd_live   = live_reg[proc_addr_reg];
    assign elap_sum  = {1'b0, rd_elap} + {1'b0, delta_reg};
    assign elap_new  = elap_sum[TIME_BITS] ? '1 : elap_sum[TIME_BITS-1:0];
    assign expire    = (elap_new >= rd_ivl);

    // id counter wraps past zero
    assign new_id = ((id_cnt_reg + 32'd1) == '0) ? 32'd1 : (id_cnt_reg + 32'd1);

    assign pick_onehot = TIMER_SLOTS'(1) << pick_slot_reg;
    assign fire_last   = ((fire_reg & ~pick_onehot) == '0)
                         || (emit_cnt_reg == ECW'(MAX_RESULTS - 1));
    assign out_free    = !m_valid_reg || m_ready;

    assign sts.is_tick   = (func_reg == FUNC_TICK);
    assign sts.fire_any  = (fire_reg != '0);
    assign sts.fire_last = fire_last;
    assign sts.out_free  = out_free;

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_comb begin
        func_next        = func_reg;
        tid_next         = tid_reg;
        per_next         = per_reg;
        ivl_next         = ivl_reg;
        delta_next       = delta_reg;
        live_next        = live_reg;
        fire_next        = fire_reg;
        id_cnt_next      = id_cnt_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        match_word_next  = match_word_reg;
        pick_found_next  = pick_found_reg;
        pick_slot_next   = pick_slot_reg;
        pick_id_next     = pick_id_reg;
        emit_cnt_next    = emit_cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_rsp_next       = m_rsp_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = proc_addr_reg;
        ram_wr_data      = ram_rd_data;

        if (cmd.load) begin
            func_next        = s_req.func;
            tid_next         = s_req.timer_id;
            per_next         = s_req.periodic;
            ivl_next         = ivl_sat;
            delta_next       = delta_sat;
            free_found_next  = 1'b0;
            match_found_next = 1'b0;
            fire_next        = '0;
            emit_cnt_next    = '0;
        end

        if (cmd.pick_start) begin
            pick_found_next = 1'b0;
        end

        // one slot word per cycle comes back from the ram
        if (proc_valid_reg) begin
            if (proc_pick_reg) begin
                // strict compare keeps the lower slot on equal ids
                if (fire_reg[proc_addr_reg] && (!pick_found_reg || (rd_id < pick_id_reg))) begin
                    pick_found_next = 1'b1;
                    pick_slot_next  = proc_addr_reg;
                    pick_id_next    = rd_id;
                end
            end else if (func_reg == FUNC_TICK) begin
                if (rd_live && !rd_halt) begin
                    ram_wr_en = 1'b1;
                    if (expire) begin
                        ram_wr_data[ELAP_LO +: TIME_BITS] = '0;
                        fire_next[proc_addr_reg]          = 1'b1;
                        if (!rd_reload) begin
                            live_next[proc_addr_reg] = 1'b0;
                        end
                    end else begin
                        ram_wr_data[ELAP_LO +: TIME_BITS] = elap_new;
                    end
                end
            end else begin
                if (!rd_live && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_slot_next  = proc_addr_reg;
                end
                if (rd_live && (rd_id == tid_reg) && (tid_reg != '0) && !match_found_reg) begin
                    match_found_next = 1'b1;
                    match_slot_next  = proc_addr_reg;
                    match_word_next  = ram_rd_data;
                end
            end
        end

        if (cmd.commit) begin
            m_valid_next              = 1'b1;
            m_rsp_next                = '0;
            m_rsp_next.last           = 1'b1;
            m_rsp_next.status         = ST_OK;
            unique case (func_reg)
                FUNC_CREATE: begin
                    if (!free_found_reg) begin
                        m_rsp_next.status = ST_FULL;
                    end else begin
                        id_cnt_next                 = new_id;
                        live_next[free_slot_reg]    = 1'b1;
                        ram_wr_en                   = 1'b1;
                        ram_wr_addr                 = free_slot_reg;
                        ram_wr_data                 = {new_id, ivl_reg, {TIME_BITS{1'b0}},
                                                       per_reg, 1'b0};
                        m_rsp_next.result_id        = new_id;
                    end
                end
                FUNC_REMOVE, FUNC_PAUSE, FUNC_RESUME: begin
                    if (!match_found_reg) begin
                        m_rsp_next.status    = ST_NOT_FOUND;
                        m_rsp_next.result_id = tid_reg;
                    end else if (func_reg == FUNC_REMOVE) begin
                        live_next[match_slot_reg] = 1'b0;
                    end else begin
                        ram_wr_en                   = 1'b1;
                        ram_wr_addr                 = match_slot_reg;
                        ram_wr_data                 = match_word_reg;
                        ram_wr_data[HALT_B]         = (func_reg == FUNC_PAUSE);
                        m_rsp_next.result_id        = tid_reg;
                    end
                end
                FUNC_CLEAR: begin
                    live_next   = '0;
                    id_cnt_next = '0;
                end
                FUNC_QUERY: begin
                    m_rsp_next.result_id = tid_reg;
                    if (!match_found_reg) begin
                        m_rsp_next.status = ST_NOT_FOUND;
                    end else begin
                        m_rsp_next.found        = 1'b1;
                        m_rsp_next.remaining_us = rem32;
                    end
                end
                default: begin
                    // tick never commits here; the unused code reports not found
                    m_rsp_next.status = ST_NOT_FOUND;
                end
            endcase
        end

        if (cmd.emit_none) begin
            m_valid_next    = 1'b1;
            m_rsp_next      = '0;
            m_rsp_next.last = 1'b1;
        end

        if (cmd.emit_fire) begin
            m_valid_next             = 1'b1;
            m_rsp_next               = '0;
            m_rsp_next.status        = ST_OK;
            m_rsp_next.result_id     = pick_id_reg;
            m_rsp_next.fired         = 1'b1;
            m_rsp_next.last          = fire_last;
            fire_next[pick_slot_reg] = 1'b0;
            emit_cnt_next            = emit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg        <= '0;
            fire_reg        <= '0;
            id_cnt_reg      <= '0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            pick_found_reg  <= 1'b0;
            emit_cnt_reg    <= '0;
            proc_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            func_reg        <= FUNC_CREATE;
        end else begin
            live_reg        <= live_next;
            fire_reg        <= fire_next;
            id_cnt_reg      <= id_cnt_next;
            free_found_reg  <= free_found_next;
            match_found_reg <= match_found_next;
            pick_found_reg  <= pick_found_next;
            emit_cnt_reg    <= emit_cnt_next;
            proc_valid_reg  <= cmd.sweep_rd;
            m_valid_reg     <= m_valid_next;
            func_reg        <= func_next;
        end
    end

    always_ff @(posedge aclk) begin
        tid_reg        <= tid_next;
        per_reg        <= per_next;
        ivl_reg        <= ivl_next;
        delta_reg      <= delta_next;
        free_slot_reg  <= free_slot_next;
        match_slot_reg <= match_slot_next;
        match_word_reg <= match_word_next;
        pick_slot_reg  <= pick_slot_next;
        pick_id_reg    <= pick_id_next;
        proc_addr_reg  <= sweep_addr;
        proc_pick_reg  <= cmd.pick_mode;
        m_rsp_reg      <= m_rsp_next;
    end

`ifndef ASSERT_OFF
    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit || cmd.emit_fire || cmd.emit_none) |-> out_free)
        else $error("result loaded while output register is held");

    a_fire_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_reg != '0) |-> (func_reg == FUNC_TICK))
        else $error("fired slots outside a tick");

    a_create_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (func_reg == FUNC_CREATE) && free_found_reg)
        |=> live_reg[$past(free_slot_reg)])
        else $error("created slot not live");
`endif

endmodule

// ===== sv/timer_slot_bank.sv =====
// channel | direction | handshake         | payload
// s_      | in        | s_valid / s_ready | s_req (tsb_req_t): one timer request
// m_      | out       | m_valid / m_ready | m_rsp (tsb_rsp_t): one result, last on final
//
// every request sweeps all slots through the slot ram, one slot per cycle:
// the result is registered after the sweep; the next request is accepted only in idle,
// after that result is loaded; a tick sweeps once more for each fired result it reports,
// each fired result coming from one ordered pass over the slots (at most 16 per tick)
// aresetn is synchronous, active low; it frees every slot and zeroes the id counter
// a held result stalls the controller at its next result; a request that follows an
// item's final result is still accepted and swept while that result waits
module timer_slot_bank import tsb_pkg::*; #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tsb_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output tsb_rsp_t m_rsp
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    tsb_cmd_t      cmd;
    tsb_sts_t      sts;
    logic [AW-1:0] sweep_addr;

    tsb_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    tsb_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_req      (s_req),
        .cmd        (cmd),
        .sweep_addr (sweep_addr),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp)
    );

endmodule

// ===== tb/tsb_checker.sv =====
module tsb_checker import tsb_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  tsb_req_t s_req,
    input  logic     m_valid,
    input  logic     m_ready,
    input  tsb_rsp_t m_rsp,
    output int       n_pending,
    output int       n_failures
);

    // shadow of the timer bank
    logic        slot_on        [SLOTS];
    logic [31:0] slot_id        [SLOTS];
    logic [31:0] slot_period_us [SLOTS];
    logic [31:0] slot_time_us   [SLOTS];
    logic        slot_repeat    [SLOTS];
    logic        slot_paused    [SLOTS];
    logic [31:0] last_issued_id;

    tsb_rsp_t expected_rsp [$];
    int       fail_count = 0;
    int       rsp_seen   = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s is %h, expected %h", $time, rsp_seen, what, got, want);
        fail_count++;
    endtask

    function automatic void push_rsp(input logic [1:0] st, input logic [31:0] id,
                                     input logic fired, input logic found,
                                     input logic [31:0] rem, input logic last);
        tsb_rsp_t r;
        r.status       = st;
        r.result_id    = id;
        r.fired        = fired;
        r.found        = found;
        r.remaining_us = rem;
        r.last         = last;
        expected_rsp   = {expected_rsp, r};
    endfunction

    // lowest numbered live slot holding the id, -1 if none or id zero
    function automatic int find_timer(input logic [31:0] id);
        int hit;
        hit = -1;
        if (id != '0) begin
            for (int s = SLOTS - 1; s >= 0; s--) begin
                if (slot_on[s] && slot_id[s] == id) begin
                    hit = s;
                end
            end
        end
        return hit;
    endfunction

    function automatic void predict_timer_op(input tsb_req_t r);
        int          s;
        int          n;
        int          j;
        logic [31:0] fire_ids [SLOTS];
        logic [31:0] key;
        logic [32:0] sum;
        case (r.func)
            FUNC_CREATE: begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_on[i]) begin
                        s = i;
                    end
                end
                if (s < 0) begin
                    push_rsp(ST_FULL, '0, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    // counter wraps past zero
                    last_issued_id    = (last_issued_id == '1) ? 32'd1 : last_issued_id + 32'd1;
                    slot_on[s]        = 1'b1;
                    slot_id[s]        = last_issued_id;
                    slot_period_us[s] = r.interval_us;
                    slot_time_us[s]   = '0;
                    slot_repeat[s]    = r.periodic;
                    slot_paused[s]    = 1'b0;
                    push_rsp(ST_OK, last_issued_id, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            FUNC_REMOVE, FUNC_PAUSE, FUNC_RESUME: begin
                s = find_timer(r.timer_id);
                if (s < 0) begin
                    push_rsp(ST_NOT_FOUND, r.timer_id, 1'b0, 1'b0, '0, 1'b1);
                end else if (r.func == FUNC_REMOVE) begin
                    slot_on[s] = 1'b0;
                    push_rsp(ST_OK, '0, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    slot_paused[s] = (r.func == FUNC_PAUSE);
                    push_rsp(ST_OK, r.timer_id, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_on[i] = 1'b0;
                end
                last_issued_id = '0;
                push_rsp(ST_OK, '0, 1'b0, 1'b0, '0, 1'b1);
            end
            FUNC_TICK: begin
                n = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_on[i] && !slot_paused[i]) begin
                        sum             = {1'b0, slot_time_us[i]} + {1'b0, r.delta_us};
                        slot_time_us[i] = sum[32] ? '1 : sum[31:0];
                        if (slot_time_us[i] >= slot_period_us[i]) begin
                            slot_time_us[i] = '0;
                            fire_ids[n]     = slot_id[i];
                            n++;
                            if (!slot_repeat[i]) begin
                                slot_on[i] = 1'b0;
                            end
                        end
                    end
                end
                // stable sort by id, ties stay in slot order
                for (int i = 1; i < n; i++) begin
                    key = fire_ids[i];
                    j   = i;
                    while (j > 0 && fire_ids[j - 1] > key) begin
                        fire_ids[j] = fire_ids[j - 1];
                        j--;
                    end
                    fire_ids[j] = key;
                end
                if (n > MAX_RESULTS) begin
                    n = MAX_RESULTS;
                end
                if (n == 0) begin
                    push_rsp(ST_OK, '0, 1'b0, 1'b0, '0, 1'b1);
                end
                for (int i = 0; i < n; i++) begin
                    push_rsp(ST_OK, fire_ids[i], 1'b1, 1'b0, '0, i == n - 1);
                end
            end
            FUNC_QUERY: begin
                s = find_timer(r.timer_id);
                if (s < 0) begin
                    push_rsp(ST_NOT_FOUND, r.timer_id, 1'b0, 1'b0, '0, 1'b1);
                end else if (slot_time_us[s] > slot_period_us[s]) begin
                    push_rsp(ST_OK, r.timer_id, 1'b0, 1'b1, '0, 1'b1);
                end else begin
                    push_rsp(ST_OK, r.timer_id, 1'b0, 1'b1,
                             slot_period_us[s] - slot_time_us[s], 1'b1);
                end
            end
            default: begin
                push_rsp(ST_NOT_FOUND, '0, 1'b0, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        tsb_rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_on[i] = 1'b0;
            end
            last_issued_id = '0;
            expected_rsp.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected result, result_id", m_rsp.result_id, '0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (m_rsp.status !== want.status)
                        report_mismatch("status", 32'(m_rsp.status), 32'(want.status));
                    if (m_rsp.result_id !== want.result_id)
                        report_mismatch("result_id", m_rsp.result_id, want.result_id);
                    if (m_rsp.fired !== want.fired)
                        report_mismatch("fired", 32'(m_rsp.fired), 32'(want.fired));
                    if (m_rsp.found !== want.found)
                        report_mismatch("found", 32'(m_rsp.found), 32'(want.found));
                    if (m_rsp.remaining_us !== want.remaining_us)
                        report_mismatch("remaining_us", m_rsp.remaining_us, want.remaining_us);
                    if (m_rsp.last !== want.last)
                        report_mismatch("last", 32'(m_rsp.last), 32'(want.last));
                end
                rsp_seen++;
            end
            if (s_valid && s_ready) begin
                predict_timer_op(s_req);
            end
        end
        n_pending  <= expected_rsp.size();
        n_failures <= fail_count;
    end

endmodule

// ===== tb/tb_timer_slot_bank.sv =====
module tb_timer_slot_bank;
    import tsb_pkg::*;

    localparam logic [2:0] FUNC_UNDEF = 3'd7;
    localparam int RANDOM_REQS  = 250;
    localparam int MAX_GAP      = 14;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tsb_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    tsb_rsp_t m_rsp;

    int n_pending;
    int n_failures;
    int cycle_count     = 0;
    int id_hint         = 0;
    int rsp_taken       = 0;
    bit send_idle       = 1'b1;
    bit recv_idle       = 1'b1;
    bit long_hold_armed = 1'b0;
    bit reset_done      = 1'b0;

    timer_slot_bank u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    tsb_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .n_pending  (n_pending),
        .n_failures (n_failures)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // every field random; callers override the ones that matter
    function automatic tsb_req_t make_req(input logic [2:0] op);
        tsb_req_t r;
        r.func        = op;
        r.timer_id    = $urandom;
        r.interval_us = $urandom;
        r.periodic    = 1'($urandom_range(0, 1));
        r.delta_us    = $urandom;
        return r;
    endfunction

    // mostly ids that were handed out recently, sometimes zero or anything
    function automatic logic [31:0] pick_id();
        int k;
        int lo;
        k  = $urandom_range(0, 9);
        lo = (id_hint > 16) ? id_hint - 16 : 1;
        if (k == 0)
            return '0;
        if (k == 1)
            return $urandom;
        return $urandom_range(lo, id_hint + 1);
    endfunction

    task automatic send_req(input tsb_req_t r);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        if (r.func == FUNC_CREATE)
            id_hint++;
        else if (r.func == FUNC_CLEAR)
            id_hint = 0;
    endtask

    // result side
    initial begin
        int hold;
        m_ready <= 1'b0;
        wait (reset_done);
        @(posedge aclk);
        forever begin
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            rsp_taken++;
            if (rsp_taken % 32 == 0)
                recv_idle = $urandom_range(0, 3) != 0;
        end
    end

    // request side
    initial begin
        tsb_req_t r;
        int       sel;
        int       k;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_req   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        reset_done = 1'b1;

        send_req(make_req(FUNC_CLEAR));
        send_req(make_req(FUNC_UNDEF));
        r = make_req(FUNC_QUERY);
        r.timer_id = '0;
        send_req(r);
        // id 1: zero interval, fires on every tick
        r = make_req(FUNC_CREATE);
        r.interval_us = '0;
        r.periodic    = 1'b1;
        send_req(r);
        // id 2: longest one-shot
        r = make_req(FUNC_CREATE);
        r.interval_us = '1;
        r.periodic    = 1'b0;
        send_req(r);
        repeat (14) begin
            r = make_req(FUNC_CREATE);
            r.interval_us = $urandom_range(1000, 32'hFFFF_FFFE);
            send_req(r);
        end
        // table full now
        send_req(make_req(FUNC_CREATE));
        r = make_req(FUNC_TICK);
        r.delta_us = '0;
        send_req(r);
        r = make_req(FUNC_PAUSE);
        r.timer_id = 32'd2;
        send_req(r);
        r = make_req(FUNC_QUERY);
        r.timer_id = 32'd2;
        send_req(r);
        r = make_req(FUNC_RESUME);
        r.timer_id = 32'd2;
        send_req(r);
        // saturating tick, every slot fires at once
        r = make_req(FUNC_TICK);
        r.delta_us = '1;
        send_req(r);
        r = make_req(FUNC_REMOVE);
        r.timer_id = 32'd1;
        send_req(r);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 32 == 0)
                send_idle = $urandom_range(0, 3) != 0;
            if (i == RANDOM_REQS / 3)
                long_hold_armed = 1'b1;
            sel = $urandom_range(0, 99);
            k   = $urandom_range(0, 9);
            if (sel < 26) begin
                r = make_req(FUNC_CREATE);
                if (k == 0)
                    r.interval_us = '0;
                else if (k > 1)
                    r.interval_us = $urandom_range(1, 3000);
            end else if (sel < 46) begin
                r = make_req(FUNC_TICK);
                if (k == 0)
                    r.delta_us = '0;
                else if (k > 1)
                    r.delta_us = $urandom_range(1, 1500);
            end else if (sel < 62) begin
                r = make_req(FUNC_QUERY);
                r.timer_id = pick_id();
            end else if (sel < 72) begin
                r = make_req(FUNC_REMOVE);
                r.timer_id = pick_id();
            end else if (sel < 81) begin
                r = make_req(FUNC_PAUSE);
                r.timer_id = pick_id();
            end else if (sel < 90) begin
                r = make_req(FUNC_RESUME);
                r.timer_id = pick_id();
            end else if (sel < 93) begin
                r = make_req(FUNC_CLEAR);
            end else if (sel < 95) begin
                r = make_req(FUNC_UNDEF);
            end else begin
                r = make_req(3'($urandom_range(0, 7)));
            end
            send_req(r);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tsb_pkg.sv
sv/tsb_ram.sv
sv/tsb_ctrl.sv
sv/tsb_dp.sv
sv/timer_slot_bank.sv
tb/tsb_checker.sv
tb/tb_timer_slot_bank.sv
